### design/lss3_pkg.sv
// lss3_pkg: shared types and constants for the 3x3 least-squares solver
// no dependencies
package lss3_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int MAT_DEPTH      = 9;
   localparam int RHS_DEPTH      = 3;
   localparam int MAT_AW         = 4;
   localparam int RHS_AW         = 2;
   localparam int IDX_W          = 2;

   typedef struct packed {
      logic [IDX_W-1:0] row_index;
      logic signed [DATA_WIDTH_DEF-1:0] coeff_0;
      logic signed [DATA_WIDTH_DEF-1:0] coeff_1;
      logic signed [DATA_WIDTH_DEF-1:0] coeff_2;
      logic signed [DATA_WIDTH_DEF-1:0] rhs;
      logic last_row;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] solution_index;
      logic signed [DATA_WIDTH_DEF-1:0] solution_value;
      logic singular;
      logic last_result;
   } rsp_type;

   // divider control between sequencer and divider
   typedef struct packed {
      logic start;
      logic neg;
   } div_ctl_type;

endpackage

### design/least_squares_solve_3x3_top.sv
// least_squares_solve_3x3_top: 3x3 least-squares solve, rows held in memory
// depends on lss3_pkg, lss3_store, lss3_seq
// a row loads in one write; the results of a solve follow its last row, one per unknown,
// each, unless the solve is singular, waiting on the bit-serial divider, which runs once per unknown;
// one solve at a time, rows refused meanwhile
// synchronous active-high reset clears control state; stored rows stay undefined until written
module least_squares_solve_3x3_top #(
   parameter int FRAC_BITS  = lss3_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  lss3_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output lss3_pkg::rsp_type rsp_data
);
   import lss3_pkg::*;

   localparam int DATA_WIDTH = DATA_WIDTH_DEF;

   logic acc, busy, start_ff;
   logic [MAT_AW-1:0] ma;
   logic [RHS_AW-1:0] ra;
   logic [DATA_WIDTH-1:0] md, rd;

   assign req_stall = busy || start_ff;
   assign acc = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) start_ff <= 1'b0;
      else start_ff <= acc && req_data.last_row;
   end

   lss3_store #(.DATA_WIDTH(DATA_WIDTH)) u_store (
      .clock(clock), .wr_en(acc && req_data.row_index != 2'd3), .wr_row(req_data.row_index),
      .wr_coeffs({DATA_WIDTH'(req_data.coeff_0), DATA_WIDTH'(req_data.coeff_1),
                  DATA_WIDTH'(req_data.coeff_2)}),
      .wr_rhs(DATA_WIDTH'(req_data.rhs)), .rd_mat_addr(ma), .rd_rhs_addr(ra),
      .rd_mat_data(md), .rd_rhs_data(rd)
   );

   lss3_seq #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_seq (
      .clock(clock), .reset(reset), .start(start_ff), .busy(busy),
      .rd_mat_addr(ma), .rd_rhs_addr(ra), .rd_mat_data(md), .rd_rhs_data(rd),
      .res_valid(rsp_valid), .res_stall(rsp_stall), .res(rsp_data)
   );

   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset) busy |-> !acc)
      else $error("row accepted during solve");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |-> (rsp_data.solution_value == '0))
      else $error("singular result not zero");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_result == (rsp_data.solution_index == 2'd2)))
      else $error("last flag mismatch");
endmodule

### design/lss3_store.sv
// lss3_store: coefficient and right-hand side memories, registered read
// depends on lss3_pkg
module lss3_store #(
   parameter int DATA_WIDTH = lss3_pkg::DATA_WIDTH_DEF
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [lss3_pkg::RHS_AW-1:0] wr_row,
   input  logic [3*DATA_WIDTH-1:0] wr_coeffs,
   input  logic [DATA_WIDTH-1:0] wr_rhs,
   input  logic [lss3_pkg::MAT_AW-1:0] rd_mat_addr,
   input  logic [lss3_pkg::RHS_AW-1:0] rd_rhs_addr,
   output logic [DATA_WIDTH-1:0] rd_mat_data,
   output logic [DATA_WIDTH-1:0] rd_rhs_data
);
   import lss3_pkg::*;

   // one row wide so a row loads in one write
   logic [3*DATA_WIDTH-1:0] mat_mem [RHS_DEPTH];
   logic [DATA_WIDTH-1:0] rhs_mem [RHS_DEPTH];
   logic [3*DATA_WIDTH-1:0] mat_row_ff;
   logic [1:0] col_ff;
   logic [RHS_AW-1:0] mrow;
   logic [1:0] mcol;

   always_comb begin
      case (rd_mat_addr)
         4'd0: begin mrow = 2'd0; mcol = 2'd0; end
         4'd1: begin mrow = 2'd0; mcol = 2'd1; end
         4'd2: begin mrow = 2'd0; mcol = 2'd2; end
         4'd3: begin mrow = 2'd1; mcol = 2'd0; end
         4'd4: begin mrow = 2'd1; mcol = 2'd1; end
         4'd5: begin mrow = 2'd1; mcol = 2'd2; end
         4'd6: begin mrow = 2'd2; mcol = 2'd0; end
         4'd7: begin mrow = 2'd2; mcol = 2'd1; end
         default: begin mrow = 2'd2; mcol = 2'd2; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mat_mem[wr_row] <= wr_coeffs;
         rhs_mem[wr_row] <= wr_rhs;
      end
      mat_row_ff  <= mat_mem[mrow];
      col_ff      <= mcol;
      rd_rhs_data <= rhs_mem[(rd_rhs_addr > 2'd2) ? 2'd2 : rd_rhs_addr];
   end

   always_comb begin
      case (col_ff)
         2'd0: rd_mat_data = mat_row_ff[3*DATA_WIDTH-1:2*DATA_WIDTH];
         2'd1: rd_mat_data = mat_row_ff[2*DATA_WIDTH-1:DATA_WIDTH];
         default: rd_mat_data = mat_row_ff[DATA_WIDTH-1:0];
      endcase
   end
endmodule

### design/lss3_div.sv
// lss3_div: bit-serial restoring divider with rounding and saturation
// depends on lss3_pkg
module lss3_div #(
   parameter int DATA_WIDTH = lss3_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = lss3_pkg::FRAC_BITS_DEF,
   parameter int NW = 6*DATA_WIDTH + 4,
   parameter int DW = 6*DATA_WIDTH + 2
) (
   input  logic clock,
   input  logic reset,
   input  lss3_pkg::div_ctl_type ctl,
   input  logic [NW-1:0] num_mag,
   input  logic [DW-1:0] den_mag,
   output logic busy,
   output logic done,
   output logic [DATA_WIDTH-1:0] quot
);
   import lss3_pkg::*;

   localparam int QW = NW + FRAC_BITS + 1;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0] n_ff;
   logic [DW:0] d_ff;
   logic [DW+1:0] r_ff;
   logic [CW-1:0] cnt_ff;
   logic neg_ff, busy_ff, done_ff;
   logic [DW+1:0] r_sh, r_sub;

   assign r_sh  = {r_ff[DW:0], n_ff[QW-1]};
   assign r_sub = r_sh - {1'b0, d_ff};

   // quotient shifts into the low bits of the numerator register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(QW);
            neg_ff  <= ctl.neg;
            // (2|n| << F) + |d| over 2|d|
            n_ff    <= ({num_mag, {(FRAC_BITS+1){1'b0}}}) + QW'(den_mag);
            d_ff    <= {den_mag, 1'b0};
            r_ff    <= '0;
         end else if (busy_ff) begin
            if (!r_sub[DW+1]) begin
               r_ff <= r_sub;
               n_ff <= {n_ff[QW-2:0], 1'b1};
            end else begin
               r_ff <= r_sh;
               n_ff <= {n_ff[QW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   logic [DATA_WIDTH-1:0] bound;
   logic big;
   always_comb begin
      bound = neg_ff ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      big = (n_ff > QW'(bound));
      if (big) quot = bound;
      else quot = neg_ff ? (DATA_WIDTH'(0) - n_ff[DATA_WIDTH-1:0]) : n_ff[DATA_WIDTH-1:0];
   end
   assign busy = busy_ff;
   assign done = done_ff;
endmodule

### design/lss3_seq.sv
// lss3_seq: solve sequencer, cofactors, then determinant and numerators over a shared multiplier
// depends on lss3_pkg, lss3_div
module lss3_seq #(
   parameter int DATA_WIDTH = lss3_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = lss3_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   output logic [lss3_pkg::MAT_AW-1:0] rd_mat_addr,
   output logic [lss3_pkg::RHS_AW-1:0] rd_rhs_addr,
   input  logic [DATA_WIDTH-1:0] rd_mat_data,
   input  logic [DATA_WIDTH-1:0] rd_rhs_data,
   output logic res_valid,
   input  logic res_stall,
   output lss3_pkg::rsp_type res
);
   import lss3_pkg::*;

   localparam int PW = 2*DATA_WIDTH + 1;
   localparam int NW = 6*DATA_WIDTH + 4;
   localparam int DW = 6*DATA_WIDTH + 2;

   typedef enum logic [2:0] {S_IDLE, S_LOAD, S_COF, S_DET, S_NUM, S_DIV, S_OUT} state_type;

   state_type state_ff;
   logic [3:0] cnt_ff;
   logic [1:0] k_ff;
   logic ph_ff;
   logic signed [DATA_WIDTH-1:0] a_ff [9];
   logic signed [DATA_WIDTH-1:0] b_ff [3];
   logic signed [PW:0] cof_ff [9];
   logic signed [NW-1:0] acc_ff;
   logic signed [NW-1:0] det_ff;
   logic sing_ff, out_v_ff;
   rsp_type out_ff;
   div_ctl_type dctl;
   logic [NW-1:0] nmag;
   logic [DW-1:0] dmag;
   logic dbusy, ddone;
   logic [DATA_WIDTH-1:0] dq;

   logic signed [PW:0] c_t;
   logic signed [NW-1:0] p_t;
   logic signed [PW:0] m_cof;
   logic signed [DATA_WIDTH-1:0] m_x;
   logic signed [DATA_WIDTH+1:0] m_part;
   logic signed [2*DATA_WIDTH+1:0] m_prod;
   logic [1:0] ci, cj, i1, i2, j1, j2;

   function automatic logic [1:0] nx(input logic [1:0] v);
      nx = (v == 2'd2) ? 2'd0 : v + 2'd1;
   endfunction

   // cofactor count in cnt_ff: row ci, column cj
   always_comb begin
      ci = (cnt_ff < 4'd3) ? 2'd0 : (cnt_ff < 4'd6) ? 2'd1 : 2'd2;
      cj = 2'(cnt_ff - 4'(ci) * 4'd3);
      i1 = nx(ci); i2 = nx(i1); j1 = nx(cj); j2 = nx(j1);
      c_t = PW'(a_ff[4'(3*i1+j1)] * a_ff[4'(3*i2+j2)])
          - PW'(a_ff[4'(3*i1+j2)] * a_ff[4'(3*i2+j1)]);
      if (state_ff == S_DET) begin
         m_x = a_ff[cnt_ff];
         m_cof = cof_ff[cnt_ff];
      end else begin
         m_x = b_ff[cnt_ff[1:0]];
         m_cof = cof_ff[4'(3*cnt_ff[1:0]+k_ff)];
      end
      // cofactor taken in two halves, low half unsigned
      m_part = ph_ff ? {m_cof[PW], m_cof[PW:DATA_WIDTH+1]} : {1'b0, m_cof[DATA_WIDTH:0]};
      m_prod = m_x * m_part;
      p_t = ph_ff ? (NW'(m_prod) <<< (DATA_WIDTH + 1)) : NW'(m_prod);
   end

   assign rd_mat_addr = cnt_ff;
   assign rd_rhs_addr = cnt_ff[1:0];

   always_comb begin
      dctl.start = (state_ff == S_NUM) && (cnt_ff == 4'd3) && !sing_ff;
      dctl.neg = acc_ff[NW-1] != det_ff[NW-1];
      nmag = acc_ff[NW-1] ? NW'(-acc_ff) : acc_ff;
      dmag = det_ff[NW-1] ? DW'(-det_ff) : DW'(det_ff);
   end

   lss3_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .NW(NW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .num_mag(nmag), .den_mag(dmag),
      .busy(dbusy), .done(ddone), .quot(dq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         cnt_ff <= '0;
         k_ff <= '0;
         ph_ff <= 1'b0;
      end else begin
         if (out_v_ff && !res_stall) out_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (start) begin
               state_ff <= S_LOAD; cnt_ff <= '0;
            end
            S_LOAD: begin
               if (cnt_ff != 4'd0) a_ff[cnt_ff-4'd1] <= rd_mat_data;
               if (cnt_ff != 4'd0 && cnt_ff < 4'd4) b_ff[2'(cnt_ff-4'd1)] <= rd_rhs_data;
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd9) begin state_ff <= S_COF; cnt_ff <= '0; end
            end
            S_COF: begin
               cof_ff[cnt_ff] <= c_t;
               cnt_ff <= cnt_ff + 4'd1;
               acc_ff <= '0;
               if (cnt_ff == 4'd8) begin state_ff <= S_DET; cnt_ff <= '0; end
            end
            S_DET: begin
               if (cnt_ff == 4'd3) begin
                  det_ff <= acc_ff; sing_ff <= (acc_ff == '0);
                  acc_ff <= '0; cnt_ff <= '0; k_ff <= '0; state_ff <= S_NUM;
               end else begin
                  acc_ff <= acc_ff + p_t; ph_ff <= !ph_ff;
                  if (ph_ff) cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_NUM: begin
               if (cnt_ff == 4'd3) begin
                  cnt_ff <= '0;
                  state_ff <= sing_ff ? S_OUT : S_DIV;
               end else begin
                  acc_ff <= acc_ff + p_t; ph_ff <= !ph_ff;
                  if (ph_ff) cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_DIV: if (ddone) state_ff <= S_OUT;
            S_OUT: if (!out_v_ff) begin
               out_v_ff <= 1'b1;
               out_ff.solution_index <= k_ff;
               out_ff.solution_value <= sing_ff ? '0 : DATA_WIDTH_DEF'(dq);
               out_ff.singular <= sing_ff;
               out_ff.last_result <= (k_ff == 2'd2);
               acc_ff <= '0;
               if (k_ff == 2'd2) state_ff <= S_IDLE;
               else begin k_ff <= k_ff + 2'd1; state_ff <= S_NUM; end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE) || dbusy;
   assign res_valid = out_v_ff;
   assign res = out_ff;
endmodule

### verif/least_squares_solve_3x3_checker.sv
`timescale 1ns / 100ps
// least_squares_solve_3x3_checker: watches both channels, predicts the solution
// of each solve from the stored rows and compares results; depends on lss3_pkg
module least_squares_solve_3x3_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  lss3_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  lss3_pkg::rsp_type rsp_data,
   output int   fail_count,
   output int   pending_count,
   output int   solve_count,
   output int   singular_count
);
   import lss3_pkg::*;

   localparam int WIDE = 160;
   typedef logic signed [WIDE-1:0] wide_t;

   logic signed [DATA_WIDTH_DEF-1:0] coeff_mem [MAT_DEPTH];
   logic signed [DATA_WIDTH_DEF-1:0] rhs_mem [RHS_DEPTH];
   rsp_type solution_queue [$];

   function automatic logic [DATA_WIDTH_DEF-1:0] round_quotient(wide_t num, wide_t det);
      logic neg;
      wide_t n, d, q, bound;
      neg = (num < 0) != (det < 0);
      n = (num < 0) ? -num : num;
      d = (det < 0) ? -det : det;
      q = ((n <<< (FRAC_BITS_DEF + 1)) + d) / (d <<< 1);
      bound = neg ? (wide_t'(1) <<< (DATA_WIDTH_DEF - 1))
                  : (wide_t'(1) <<< (DATA_WIDTH_DEF - 1)) - 1;
      if (q > bound) q = bound;
      if (neg) q = -q;
      return q[DATA_WIDTH_DEF-1:0];
   endfunction

   task automatic predict_solution();
      wide_t a [3][3];
      wide_t b [3];
      wide_t cof [3][3];
      wide_t det, num;
      rsp_type r;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) a[i][j] = wide_t'(coeff_mem[i*3+j]);
         b[i] = wide_t'(rhs_mem[i]);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                      - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
         end
      end
      det = 0;
      for (int j = 0; j < 3; j++) det += a[0][j] * cof[0][j];
      solve_count++;
      if (det == 0) singular_count++;
      for (int i = 0; i < 3; i++) begin
         num = 0;
         for (int j = 0; j < 3; j++) num += cof[j][i] * b[j];
         r.solution_index = IDX_W'(i);
         r.singular = (det == 0);
         r.solution_value = (det == 0) ? '0 : round_quotient(num, det);
         r.last_result = (i == 2);
         solution_queue.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         solution_queue.delete();
         fail_count <= 0;
         solve_count = 0;
         singular_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.row_index < 3) begin
               coeff_mem[req_data.row_index*3+0] = req_data.coeff_0;
               coeff_mem[req_data.row_index*3+1] = req_data.coeff_1;
               coeff_mem[req_data.row_index*3+2] = req_data.coeff_2;
               rhs_mem[req_data.row_index] = req_data.rhs;
            end
            if (req_data.last_row) predict_solution();
         end
         if (rsp_valid && !rsp_stall) begin
            if (solution_queue.size() == 0) begin
               $display("%0t: unexpected result, actual %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = solution_queue.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= solution_queue.size();
   end

endmodule

### verif/least_squares_solve_3x3_top_tb.sv
`timescale 1ns / 100ps
// least_squares_solve_3x3_top_tb: stimulus, stall bursts and verdict for the solver
// depends on lss3_pkg, least_squares_solve_3x3_top and least_squares_solve_3x3_checker
module least_squares_solve_3x3_top_tb;
   import lss3_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   int fail_count, pending_count, solve_count, singular_count;
   bit quiet;

   least_squares_solve_3x3_top u_dut (.*);
   least_squares_solve_3x3_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   // receiver stall bursts
   initial begin
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   function automatic logic [31:0] rand_value(int kind);
      case (kind)
         0: return $urandom;
         1: return $signed($urandom_range(0, 16)) - 8 <<< 16;
         2: return $signed($urandom_range(0, 32'h3ffff)) - 32'h20000;
         default: return $signed($urandom_range(0, 32'hffffff)) - 32'h800000;
      endcase
   endfunction

   task automatic send(logic [1:0] row, logic [31:0] c0, logic [31:0] c1,
                       logic [31:0] c2, logic [31:0] r, logic last);
      req_data <= '{row, c0, c1, c2, r, last};
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_random_row(logic [1:0] row, logic last);
      int kind;
      kind = $urandom_range(0, 3);
      send(row, rand_value(kind), rand_value(kind), rand_value(kind), rand_value(kind), last);
   endtask

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;

   initial begin
      int order [3];
      int t;
      req_valid = 0;
      req_data = '0;
      reset = 1;
      quiet = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // identity with extreme right-hand side
      send(0, ONE, 0, 0, MAXV, 0);
      send(1, 0, ONE, 0, MINV, 0);
      send(2, 0, 0, ONE, 32'hffff_ffff, 1);
      // all-zero matrix is singular
      send(0, 0, 0, 0, ONE, 0);
      send(1, 0, 0, 0, ONE, 0);
      send(2, 0, 0, 0, ONE, 1);
      // tiny determinant saturates both ways
      send(0, 1, 0, 0, MAXV, 0);
      send(1, 0, 1, 0, MINV, 0);
      send(2, 0, 0, 32'hffff_ffff, MAXV, 1);
      // extreme coefficients
      send(0, MAXV, MINV, MAXV, MINV, 0);
      send(1, MINV, MAXV, 1, MAXV, 0);
      send(2, MAXV, 0, MINV, 1, 1);
      // unused row index, then restart on stored rows
      send(3, MAXV, MAXV, MAXV, MAXV, 0);
      send(3, 0, ONE, ONE, ONE, 1);
      // single row update then solve; duplicate rows make it singular
      send(1, MAXV, MINV, MAXV, 0, 1);
      send(2, MAXV, MINV, MAXV, ONE, 1);
      // rounding: x = 1/3 in Q16.16
      send(0, 3 * ONE, 0, 0, ONE, 0);
      send(1, 0, ONE, 0, 32'hffff_8000, 0);
      send(2, 0, 0, 2 * ONE, 32'h0000_0001, 1);

      t = 19;
      while (t < 320) begin
         if (t > 290) begin
            quiet = 1;
         end
         if ($urandom_range(0, 9) < 8) begin
            order = '{0, 1, 2};
            order.shuffle();
            for (int k = 0; k < 3; k++) send_random_row(order[k], k == 2);
            t += 3;
         end else begin
            send_random_row($urandom_range(0, 3), $urandom_range(0, 1));
            t++;
         end
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (800) @(posedge clock);
      $display("ran %0d solves, %0d singular, with stalls on both channels",
               solve_count, singular_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
